// ===== hw/rtl/tlptm_pkg.sv =====
// Package for the two-level page table mapper.
// Holds store geometry, request codes, status codes and reset values.
// No dependencies.
package tlptm_pkg;

    localparam int FRAMES_DEFAULT = 64;
    localparam int PAGE_ENTRIES   = 1024;
    localparam int IDX_BITS       = 10;
    localparam int DIR_SHIFT      = 22;
    localparam int FRAME_SHIFT    = 12;
    localparam int FRAME_BITS     = 20;

    localparam logic [1:0] REQ_MAP   = 2'd0;
    localparam logic [1:0] REQ_UNMAP = 2'd1;
    localparam logic [1:0] REQ_READ  = 2'd2;
    localparam logic [1:0] REQ_NOP   = 2'd3;

    localparam logic [1:0] STAT_OK       = 2'd0;
    localparam logic [1:0] STAT_NO_FRAME = 2'd1;
    localparam logic [1:0] STAT_BEYOND   = 2'd2;

    localparam logic [5:0] FREE_START_RESET = 6'd1;

endpackage

// ===== hw/rtl/tlptm_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module tlptm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== hw/rtl/two_level_page_table_mapper.sv =====
// Two-level page table mapper: top level with the request sequencer.
// Depends on tlptm_pkg and tlptm_ram.
//
// After reset the block zeroes its whole entry store, one word per cycle, and
// holds busy high until every word is cleared. A request is taken when start
// is high and busy is low; its result beat appears on the result ports with
// done high for exactly one cycle and must be captured then. A request of the
// unused type or one whose directory frame lies beyond the store returns in
// the cycle after it is taken. Reads, unmaps and maps that need no new table
// or find no free frame pass through S_LOOKUP and S_EVAL, which registers the
// result. A map that allocates a new table clears it word by word through
// the store's one write port (S_ZERO), writes the directory entry (S_DIR_WR)
// and the table entry (S_TBL_WR). busy stays high until the result is issued.
module two_level_page_table_mapper #(
    parameter int FRAMES = tlptm_pkg::FRAMES_DEFAULT
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  req_type,
    input  logic [31:0] virt_addr,
    input  logic [5:0]  dir_frame,
    input  logic [31:0] phys_addr,
    input  logic        user_bit,
    input  logic [9:0]  entry_index,
    output logic        done,
    output logic [1:0]  status,
    output logic        new_table,
    output logic [5:0]  table_frame,
    output logic [31:0] read_word,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [5:0]  cfg_data
);

    localparam int IB    = tlptm_pkg::IDX_BITS;
    localparam int FB    = tlptm_pkg::FRAME_BITS;
    localparam int FW    = $clog2(FRAMES);
    localparam int DEPTH = FRAMES * tlptm_pkg::PAGE_ENTRIES;
    localparam int AW    = $clog2(DEPTH);
    localparam int CNTW  = $clog2(FRAMES + 1);
    localparam logic [FB-1:0] FRAMES_W   = FB'(FRAMES);
    localparam logic [AW-1:0] LAST_ADDR  = AW'(DEPTH - 1);
    localparam logic [IB-1:0] LAST_INDEX = {IB{1'b1}};

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_LOOKUP,
        S_EVAL,
        S_ZERO,
        S_DIR_WR,
        S_TBL_WR
    } state_t;

    state_t          state_reg;
    logic [AW-1:0]   cnt_reg;
    logic [CNTW-1:0] alloc_reg;
    logic [5:0]      free_start_reg;
    logic [1:0]      req_reg;
    logic [IB-1:0]   didx_reg;
    logic [IB-1:0]   tidx_reg;
    logic [IB-1:0]   ridx_reg;
    logic [5:0]      dir_frame_reg;
    logic [FB-1:0]   pa_reg;
    logic            user_reg;
    logic [FW-1:0]   tframe_reg;
    logic            done_reg;
    logic [1:0]      status_reg;
    logic            new_table_reg;
    logic [5:0]      table_frame_reg;
    logic [31:0]     read_word_reg;

    logic            ram_we;
    logic [AW-1:0]   ram_waddr;
    logic [31:0]     ram_wdata;
    logic [AW-1:0]   ram_raddr;
    logic [31:0]     ram_rdata;

    logic [FB-1:0]   dir_ext;
    logic [FB-1:0]   in_dir_ext;
    logic [FB-1:0]   ent_frame;
    logic            ent_beyond;
    logic            ent_present;
    logic [FB-1:0]   next_frame;
    logic            next_beyond;
    logic [FB-1:0]   tframe_ext;
    logic [31:0]     table_entry;
    logic [31:0]     pde_word;

    assign dir_ext     = FB'(dir_frame_reg);
    assign in_dir_ext  = FB'(dir_frame);
    assign ent_frame   = ram_rdata[31:tlptm_pkg::FRAME_SHIFT];
    assign ent_beyond  = ent_frame >= FRAMES_W;
    assign ent_present = ram_rdata[0];
    assign next_frame  = FB'(free_start_reg) + FB'(alloc_reg);
    assign next_beyond = next_frame >= FRAMES_W;
    assign tframe_ext  = FB'(tframe_reg);
    assign table_entry = {pa_reg, 9'd0, user_reg, 2'b11};
    assign pde_word    = {tframe_ext, 9'd0, user_reg, 2'b11};

    assign ram_raddr = (req_reg == tlptm_pkg::REQ_READ) ? {dir_ext[FW-1:0], ridx_reg}
                                                        : {dir_ext[FW-1:0], didx_reg};

    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = cnt_reg;
        ram_wdata = '0;
        case (state_reg)
            S_CLEAR:
            begin
                ram_we = 1'b1;
            end
            S_EVAL:
            begin
                if (req_reg == tlptm_pkg::REQ_UNMAP && !ent_beyond)
                begin
                    ram_we    = 1'b1;
                    ram_waddr = {ent_frame[FW-1:0], tidx_reg};
                end
                else if (req_reg == tlptm_pkg::REQ_MAP && ent_present && !ent_beyond)
                begin
                    ram_we    = 1'b1;
                    ram_waddr = {ent_frame[FW-1:0], tidx_reg};
                    ram_wdata = table_entry;
                end
            end
            S_ZERO:
            begin
                ram_we    = 1'b1;
                ram_waddr = {tframe_reg, cnt_reg[IB-1:0]};
            end
            S_DIR_WR:
            begin
                ram_we    = 1'b1;
                ram_waddr = {dir_ext[FW-1:0], didx_reg};
                ram_wdata = pde_word;
            end
            S_TBL_WR:
            begin
                ram_we    = 1'b1;
                ram_waddr = {tframe_reg, tidx_reg};
                ram_wdata = table_entry;
            end
            default:
            begin
                ram_we = 1'b0;
            end
        endcase
    end

    tlptm_ram #(
        .WIDTH(32),
        .DEPTH(DEPTH)
    ) u_store (
        .clk  (clk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(ram_wdata),
        .raddr(ram_raddr),
        .rdata(ram_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_CLEAR;
            cnt_reg         <= '0;
            alloc_reg       <= '0;
            free_start_reg  <= tlptm_pkg::FREE_START_RESET;
            req_reg         <= tlptm_pkg::REQ_NOP;
            didx_reg        <= '0;
            tidx_reg        <= '0;
            ridx_reg        <= '0;
            dir_frame_reg   <= '0;
            pa_reg          <= '0;
            user_reg        <= 1'b0;
            tframe_reg      <= '0;
            done_reg        <= 1'b0;
            status_reg      <= tlptm_pkg::STAT_OK;
            new_table_reg   <= 1'b0;
            table_frame_reg <= '0;
            read_word_reg   <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (cfg_valid)
            begin
                free_start_reg <= cfg_data;
            end
            case (state_reg)
                S_CLEAR:
                begin
                    cnt_reg <= cnt_reg + AW'(1);
                    if (cnt_reg == LAST_ADDR)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                S_IDLE:
                begin
                    if (start)
                    begin
                        req_reg         <= req_type;
                        didx_reg        <= virt_addr[31:tlptm_pkg::DIR_SHIFT];
                        tidx_reg        <= virt_addr[tlptm_pkg::DIR_SHIFT-1:
                                                     tlptm_pkg::FRAME_SHIFT];
                        ridx_reg        <= entry_index;
                        dir_frame_reg   <= dir_frame;
                        pa_reg          <= phys_addr[31:tlptm_pkg::FRAME_SHIFT];
                        user_reg        <= user_bit;
                        new_table_reg   <= 1'b0;
                        table_frame_reg <= '0;
                        read_word_reg   <= '0;
                        if (req_type == tlptm_pkg::REQ_NOP)
                        begin
                            done_reg   <= 1'b1;
                            status_reg <= tlptm_pkg::STAT_OK;
                        end
                        else if (in_dir_ext >= FRAMES_W)
                        begin
                            done_reg   <= 1'b1;
                            status_reg <= tlptm_pkg::STAT_BEYOND;
                        end
                        else
                        begin
                            state_reg <= S_LOOKUP;
                        end
                    end
                end
                S_LOOKUP:
                begin
                    state_reg <= S_EVAL;
                end
                S_EVAL:
                begin
                    state_reg <= S_IDLE;
                    done_reg  <= 1'b1;
                    if (req_reg == tlptm_pkg::REQ_READ)
                    begin
                        status_reg    <= tlptm_pkg::STAT_OK;
                        read_word_reg <= ram_rdata;
                    end
                    else if (req_reg == tlptm_pkg::REQ_UNMAP || ent_present)
                    begin
                        if (ent_beyond)
                        begin
                            status_reg <= tlptm_pkg::STAT_BEYOND;
                        end
                        else
                        begin
                            status_reg      <= tlptm_pkg::STAT_OK;
                            table_frame_reg <= ent_frame[5:0];
                        end
                    end
                    else if (next_beyond)
                    begin
                        status_reg <= tlptm_pkg::STAT_NO_FRAME;
                    end
                    else
                    begin
                        done_reg   <= 1'b0;
                        state_reg  <= S_ZERO;
                        alloc_reg  <= alloc_reg + CNTW'(1);
                        tframe_reg <= next_frame[FW-1:0];
                        cnt_reg    <= '0;
                    end
                end
                S_ZERO:
                begin
                    cnt_reg <= cnt_reg + AW'(1);
                    if (cnt_reg[IB-1:0] == LAST_INDEX)
                    begin
                        state_reg <= S_DIR_WR;
                    end
                end
                S_DIR_WR:
                begin
                    state_reg <= S_TBL_WR;
                end
                S_TBL_WR:
                begin
                    state_reg       <= S_IDLE;
                    done_reg        <= 1'b1;
                    status_reg      <= tlptm_pkg::STAT_OK;
                    new_table_reg   <= 1'b1;
                    table_frame_reg <= tframe_ext[5:0];
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign busy        = (state_reg != S_IDLE);
    assign cfg_ready   = 1'b1;
    assign done        = done_reg;
    assign status      = status_reg;
    assign new_table   = new_table_reg;
    assign table_frame = table_frame_reg;
    assign read_word   = read_word_reg;

endmodule

// ===== tb/two_level_page_table_mapper_tb.sv =====
// Testbench for two_level_page_table_mapper: map, unmap and read requests checked
// beat by beat against a page-table walk kept in the bench, under several allocator settings.
// Depends on tlptm_pkg and the mapper RTL.
`timescale 1ns / 100ps

module two_level_page_table_mapper_tb;

    localparam int FRAMES      = tlptm_pkg::FRAMES_DEFAULT;
    localparam int PAGE_WORDS  = tlptm_pkg::PAGE_ENTRIES;
    localparam int IDLE_LIMIT  = 300000;

    typedef struct packed {
        logic [1:0]  req;
        logic [31:0] va;
        logic [5:0]  df;
        logic [31:0] pa;
        logic        user;
        logic [9:0]  idx;
    } map_req_t;

    typedef struct packed {
        logic [1:0]  status;
        logic        new_table;
        logic [5:0]  table_frame;
        logic [31:0] read_word;
    } map_result_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        start = 1'b0;
    logic [1:0]  req_type = tlptm_pkg::REQ_NOP;
    logic [31:0] virt_addr = '0;
    logic [5:0]  dir_frame = '0;
    logic [31:0] phys_addr = '0;
    logic        user_bit = 1'b0;
    logic [9:0]  entry_index = '0;
    logic        cfg_valid = 1'b0;
    logic [5:0]  cfg_data = '0;
    logic        busy;
    logic        done;
    logic [1:0]  status;
    logic        new_table;
    logic [5:0]  table_frame;
    logic [31:0] read_word;
    logic        cfg_ready;

    bit [31:0]   page_store [0:FRAMES*PAGE_WORDS-1];
    int          frames_used = 0;
    int          free_start = int'(tlptm_pkg::FREE_START_RESET);

    map_req_t    request_queue[$];
    map_result_t results_due[$];
    map_req_t    drive_item;
    map_result_t seen_want;
    bit          item_held = 1'b0;
    int          hold_off = 0;
    int          burst_left = 0;
    int          idle_cycles = 0;

    int          mismatches = 0;
    int          requests_taken = 0;
    int          maps_seen = 0;
    int          tables_made = 0;
    int          no_frame_seen = 0;
    int          beyond_seen = 0;
    int          cfg_writes = 0;

    two_level_page_table_mapper #(.FRAMES(FRAMES)) dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .req_type    (req_type),
        .virt_addr   (virt_addr),
        .dir_frame   (dir_frame),
        .phys_addr   (phys_addr),
        .user_bit    (user_bit),
        .entry_index (entry_index),
        .done        (done),
        .status      (status),
        .new_table   (new_table),
        .table_frame (table_frame),
        .read_word   (read_word),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_data    (cfg_data)
    );

    always #1 clk = ~clk;

    function automatic map_result_t walk_tables(input map_req_t r);
        map_result_t res;
        logic [9:0]  didx;
        logic [9:0]  tidx;
        logic [31:0] dentry;
        int          tframe;
        res = '0;
        didx = r.va[31:22];
        tidx = r.va[21:12];
        if (r.req == tlptm_pkg::REQ_NOP)
            return res;
        if (r.df >= FRAMES)
        begin
            res.status = tlptm_pkg::STAT_BEYOND;
            beyond_seen++;
            return res;
        end
        if (r.req == tlptm_pkg::REQ_READ)
        begin
            res.read_word = page_store[r.df * PAGE_WORDS + r.idx];
            return res;
        end
        dentry = page_store[r.df * PAGE_WORDS + didx];
        if (r.req == tlptm_pkg::REQ_UNMAP || dentry[0])
        begin
            tframe = int'(dentry[31:12]);
            if (tframe >= FRAMES)
            begin
                res.status = tlptm_pkg::STAT_BEYOND;
                beyond_seen++;
                return res;
            end
            if (r.req == tlptm_pkg::REQ_UNMAP)
            begin
                page_store[tframe * PAGE_WORDS + tidx] = '0;
                res.table_frame = tframe[5:0];
                return res;
            end
        end
        else
        begin
            tframe = free_start + frames_used;
            if (tframe >= FRAMES)
            begin
                res.status = tlptm_pkg::STAT_NO_FRAME;
                no_frame_seen++;
                return res;
            end
            frames_used++;
            tables_made++;
            for (int i = 0; i < PAGE_WORDS; i++)
                page_store[tframe * PAGE_WORDS + i] = '0;
            page_store[r.df * PAGE_WORDS + didx] = {tframe[19:0], 9'd0, r.user, 2'b11};
            res.new_table = 1'b1;
        end
        page_store[tframe * PAGE_WORDS + tidx] = {r.pa[31:12], 9'd0, r.user, 2'b11};
        res.table_frame = tframe[5:0];
        maps_seen++;
        return res;
    endfunction

    function automatic int pick_gap();
        int roll;
        if (burst_left > 0)
        begin
            burst_left--;
            return 0;
        end
        roll = $urandom_range(0, 99);
        if (roll < 3)
        begin
            burst_left = $urandom_range(20, 60);
            return 0;
        end
        if (roll < 50)
            return 0;
        if (roll < 88)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic map_req_t mk_req(input logic [1:0] req, input logic [31:0] va,
                                        input logic [5:0] df, input logic [31:0] pa,
                                        input logic user, input logic [9:0] idx);
        map_req_t r;
        r.req = req;
        r.va = va;
        r.df = df;
        r.pa = pa;
        r.user = user;
        r.idx = idx;
        return r;
    endfunction

    function automatic logic [9:0] pick_index();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 20)
            return 10'd0;
        if (roll < 35)
            return 10'd1023;
        if (roll < 60)
            return 10'($urandom_range(1, 3));
        return 10'($urandom);
    endfunction

    function automatic logic [5:0] pick_frame();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 55)
            return 6'($urandom_range(0, 7));
        if (roll < 75)
            return 6'($urandom_range(60, 63));
        return 6'($urandom);
    endfunction

    function automatic map_req_t random_request(input logic [1:0] req);
        return mk_req(req, {pick_index(), pick_index(), 12'($urandom)}, pick_frame(),
                      $urandom, 1'($urandom), pick_index());
    endfunction

    task automatic queue_random(input int count);
        int       added;
        int       roll;
        map_req_t r;
        added = 0;
        while (added < count)
        begin
            roll = $urandom_range(0, 99);
            if (roll < 30)
            begin
                // Map, then read back the directory entry, then often unmap.
                r = random_request(tlptm_pkg::REQ_MAP);
                request_queue.push_back(r);
                request_queue.push_back(mk_req(tlptm_pkg::REQ_READ, $urandom, r.df,
                                               $urandom, 1'($urandom), r.va[31:22]));
                added += 2;
                if ($urandom_range(0, 1) == 1)
                begin
                    r.req = tlptm_pkg::REQ_UNMAP;
                    request_queue.push_back(r);
                    added++;
                end
            end
            else if (roll < 58)
            begin
                request_queue.push_back(random_request(tlptm_pkg::REQ_MAP));
                added++;
            end
            else if (roll < 72)
            begin
                request_queue.push_back(random_request(tlptm_pkg::REQ_UNMAP));
                added++;
            end
            else if (roll < 94)
            begin
                request_queue.push_back(random_request(tlptm_pkg::REQ_READ));
                added++;
            end
            else
            begin
                request_queue.push_back(random_request(tlptm_pkg::REQ_NOP));
                added++;
            end
        end
    endtask

    task automatic wait_idle();
        do
            @(posedge clk);
        while (request_queue.size() != 0 || item_held || results_due.size() != 0);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_free_start(input logic [5:0] value);
        wait_idle();
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        free_start = int'(value);
        cfg_writes++;
        cfg_valid <= 1'b0;
    endtask

    task automatic flag_mismatch(input string what, input logic [31:0] want,
                                 input logic [31:0] got);
        mismatches++;
        $display("[%0t] MISMATCH %s: expected 0x%0h, got 0x%0h", $realtime, what, want, got);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start <= 1'b0;
        end
        else
        begin
            if (start && !busy)
            begin
                results_due.push_back(walk_tables(drive_item));
                requests_taken++;
                item_held = 1'b0;
                hold_off = pick_gap();
            end
            if (!start || !busy)
            begin
                if (hold_off > 0 || request_queue.size() == 0)
                begin
                    if (hold_off > 0)
                        hold_off--;
                    start <= 1'b0;
                end
                else
                begin
                    drive_item = request_queue.pop_front();
                    item_held = 1'b1;
                    start       <= 1'b1;
                    req_type    <= drive_item.req;
                    virt_addr   <= drive_item.va;
                    dir_frame   <= drive_item.df;
                    phys_addr   <= drive_item.pa;
                    user_bit    <= drive_item.user;
                    entry_index <= drive_item.idx;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (results_due.size() == 0)
            begin
                flag_mismatch("result beat with no request outstanding", '0, 32'(status));
            end
            else
            begin
                seen_want = results_due.pop_front();
                if (status !== seen_want.status)
                    flag_mismatch("status", 32'(seen_want.status), 32'(status));
                if (new_table !== seen_want.new_table)
                    flag_mismatch("new_table", 32'(seen_want.new_table), 32'(new_table));
                if (table_frame !== seen_want.table_frame)
                    flag_mismatch("table_frame", 32'(seen_want.table_frame),
                                  32'(table_frame));
                if (read_word !== seen_want.read_word)
                    flag_mismatch("read_word", seen_want.read_word, read_word);
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || done || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("Timeout: no beat for %0d cycles, %0d results outstanding",
                     IDLE_LIMIT, results_due.size());
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        write_free_start(6'd63);
        request_queue.push_back(mk_req(tlptm_pkg::REQ_MAP, 32'h0000_0000, 6'd5,
                                       32'hFFFF_FFFF, 1'b1, 10'd0));
        request_queue.push_back(mk_req(tlptm_pkg::REQ_MAP, 32'hFFFF_FFFF, 6'd5,
                                       32'h0000_0000, 1'b0, 10'd0));
        request_queue.push_back(mk_req(tlptm_pkg::REQ_READ, 32'h0, 6'd5, 32'h0, 1'b0,
                                       10'd0));
        request_queue.push_back(mk_req(tlptm_pkg::REQ_READ, 32'h0, 6'd63, 32'h0, 1'b0,
                                       10'd0));
        request_queue.push_back(mk_req(tlptm_pkg::REQ_MAP, 32'h0000_1000, 6'd5,
                                       32'h1234_5000, 1'b0, 10'd0));
        request_queue.push_back(mk_req(tlptm_pkg::REQ_MAP, 32'h0000_0000, 6'd63,
                                       32'hABCD_E000, 1'b1, 10'd0));
        request_queue.push_back(mk_req(tlptm_pkg::REQ_UNMAP, 32'h0000_0000, 6'd63,
                                       32'h0, 1'b0, 10'd0));
        request_queue.push_back(mk_req(tlptm_pkg::REQ_UNMAP, 32'h0040_0000, 6'd6,
                                       32'h0, 1'b0, 10'd0));
        request_queue.push_back(mk_req(tlptm_pkg::REQ_NOP, 32'hFFFF_FFFF, 6'd63,
                                       32'hFFFF_FFFF, 1'b1, 10'd1023));

        write_free_start(6'd0);
        request_queue.push_back(mk_req(tlptm_pkg::REQ_MAP, 32'h00C0_3000, 6'd1,
                                       32'h0000_0000, 1'b0, 10'd0));
        request_queue.push_back(mk_req(tlptm_pkg::REQ_READ, 32'h0, 6'd1, 32'h0, 1'b0,
                                       10'd3));
        request_queue.push_back(mk_req(tlptm_pkg::REQ_MAP, 32'h00C0_5000, 6'd1,
                                       32'h5555_5000, 1'b1, 10'd0));
        request_queue.push_back(mk_req(tlptm_pkg::REQ_UNMAP, 32'h0000_1000, 6'd5,
                                       32'h0, 1'b0, 10'd0));
        request_queue.push_back(mk_req(tlptm_pkg::REQ_READ, 32'h0, 6'd63, 32'h0, 1'b0,
                                       10'd1));
        request_queue.push_back(mk_req(tlptm_pkg::REQ_READ, 32'h0, 6'd0, 32'h0, 1'b0,
                                       10'd1023));
        request_queue.push_back(mk_req(tlptm_pkg::REQ_MAP, 32'hFFFF_FFFF, 6'd63,
                                       32'hFFFF_FFFF, 1'b1, 10'd0));
        request_queue.push_back(mk_req(tlptm_pkg::REQ_MAP, 32'hFFFF_FFFF, 6'd63,
                                       32'hAAAA_A000, 1'b0, 10'd0));
        request_queue.push_back(mk_req(tlptm_pkg::REQ_READ, 32'h0, 6'd2, 32'h0, 1'b0,
                                       10'd1023));
        request_queue.push_back(mk_req(tlptm_pkg::REQ_UNMAP, 32'hFFFF_FFFF, 6'd63,
                                       32'h0, 1'b0, 10'd0));
        request_queue.push_back(mk_req(tlptm_pkg::REQ_READ, 32'h0, 6'd2, 32'h0, 1'b0,
                                       10'd1023));
        queue_random(260);

        write_free_start(6'($urandom_range(10, 50)));
        queue_random(160);

        write_free_start(6'd63);
        queue_random(140);

        wait_idle();
        repeat (10) @(posedge clk);

        $display("Covered %0d requests: %0d maps written, %0d tables allocated,",
                 requests_taken, maps_seen, tables_made);
        $display("%0d refused for lack of a frame, %0d beyond the store, %0d allocator writes.",
                 no_frame_seen, beyond_seen, cfg_writes);
        if (mismatches == 0 && results_due.size() == 0)
        begin
            $display("*** PASSED ***");
        end
        else
        begin
            $display("%0d mismatches, %0d results never arrived", mismatches, results_due.size());
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

// ===== files.f =====
hw/rtl/tlptm_pkg.sv
hw/rtl/tlptm_ram.sv
hw/rtl/two_level_page_table_mapper.sv
tb/two_level_page_table_mapper_tb.sv
